/* hw/rtl/sha256_pkg.sv */
`default_nettype none
package sha256_pkg;

  // Depth of the word queue between padding front and compression back
  localparam int unsigned QueueDepth = 4;

  // One schedule word as it travels from front to back
  typedef struct packed {
    logic        start;   // first word of a new message: reload hash, restart block
    logic        fin;     // last padded word: emit digest after this block
    logic [31:0] word;
  } qent_t;

  localparam logic [31:0] PadOne = 32'h8000_0000;

  // Initial hash values
  function automatic logic [31:0] h_init(input logic [2:0] idx);
    logic [31:0] h;
    unique case (idx)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      3'd7: h = 32'h5be0cd19;
      default: h = 32'h0;
    endcase
    return h;
  endfunction

  // Round constants
  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/sha256_front.sv */
`default_nettype none
module sha256_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [39:0]       in_tdata,   // msg_word[31:0], valid_bytes[34:32], zeros
  input  wire logic              in_tuser,   // first_word
  input  wire logic              in_tlast,   // last_word
  output logic                   q_push,
  output sha256_pkg::qent_t      q_data,
  input  wire logic              q_full
);

  typedef enum logic [1:0] {F_IN, F_P80, F_ZERO, F_LLO} fstate_t;

  fstate_t     state_r, state_nxt;
  logic [63:0] len_r, len_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  logic [2:0]  vb;
  logic [63:0] base_len;
  logic [3:0]  base_cnt;
  logic [31:0] msg;
  logic [31:0] pword;

  assign in_tready = (state_r == F_IN) && !q_full;

  // Clamp byte count, build padded last word
  always_comb begin
    msg = in_tdata[31:0];
    vb  = in_tdata[34:32];
    if (vb > 3'd4) vb = 3'd4;
    if (!in_tlast) vb = 3'd4;
    base_len = in_tuser ? 64'd0 : len_r;
    base_cnt = in_tuser ? 4'd0 : cnt_r;
    unique case (vb)
      3'd0:    pword = sha256_pkg::PadOne;
      3'd1:    pword = {msg[31:24], 24'h80_0000};
      3'd2:    pword = {msg[31:16], 16'h8000};
      3'd3:    pword = {msg[31:8], 8'h80};
      default: pword = msg;
    endcase
  end

  // Emit one schedule word per cycle while the queue is not full, padding after the last word
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    q_push    = 1'b0;
    q_data    = '0;
    unique case (state_r)
      F_IN: begin
        if (in_tvalid && !q_full) begin
          q_push       = 1'b1;
          q_data.start = in_tuser;
          q_data.word  = pword;
          len_nxt      = base_len + {58'd0, vb, 3'b000};
          cnt_nxt      = base_cnt + 4'd1;
          if (in_tlast) state_nxt = (vb == 3'd4) ? F_P80 : F_ZERO;
        end
      end
      F_P80: begin
        if (!q_full) begin
          q_push      = 1'b1;
          q_data.word = sha256_pkg::PadOne;
          cnt_nxt     = cnt_r + 4'd1;
          state_nxt   = F_ZERO;
        end
      end
      F_ZERO: begin
        if (!q_full) begin
          q_push  = 1'b1;
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_r == 4'd14) begin
            q_data.word = len_r[63:32];
            state_nxt   = F_LLO;
          end
        end
      end
      F_LLO: begin
        if (!q_full) begin
          q_push      = 1'b1;
          q_data.fin  = 1'b1;
          q_data.word = len_r[31:0];
          cnt_nxt     = 4'd0;
          len_nxt     = 64'd0;
          state_nxt   = F_IN;
        end
      end
      default: state_nxt = F_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IN;
      len_r   <= 64'd0;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sha256_fifo.sv */
`default_nettype none
module sha256_fifo #(
  parameter int unsigned DEPTH = sha256_pkg::QueueDepth
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire sha256_pkg::qent_t din,
  output logic                   full,
  input  wire logic              pop,
  output sha256_pkg::qent_t      dout,
  output logic                   empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);

  sha256_pkg::qent_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // Store on push
  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= din;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      if (pop && !empty) rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      if ((push && !full) && !(pop && !empty)) count_r <= count_r + 1'b1;
      else if (!(push && !full) && (pop && !empty)) count_r <= count_r - 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue occupancy beyond depth");
`endif

endmodule
`default_nettype wire

/* hw/rtl/sha256_back.sv */
`default_nettype none
module sha256_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sha256_pkg::qent_t q_data,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [39:0]            out_tdata,  // digest_word[31:0], word_index[34:32], zeros
  output logic                   out_tlast   // digest_last
);

  typedef enum logic [1:0] {B_FILL, B_COMP, B_ADD, B_OUT} bstate_t;

  bstate_t     state_r;
  logic [31:0] win_r  [16];
  logic [31:0] v_r    [8];
  logic [31:0] hash_r [8];
  logic [3:0]  cnt_r;
  logic [5:0]  rnd_r;
  logic        fin_r;
  logic [2:0]  oidx_r;
  logic        out_tvalid_r;
  logic [31:0] out_data_r;
  logic [2:0]  out_idx_r;
  logic        out_last_r;

  logic [31:0] s0, s1, w_new, e, a, t1, t2;

  assign q_pop      = (state_r == B_FILL) && !q_empty;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_idx_r, out_data_r};
  assign out_tlast  = out_last_r;

  // One schedule step and one round
  always_comb begin
    s0 = {win_r[1][6:0], win_r[1][31:7]} ^ {win_r[1][17:0], win_r[1][31:18]}
       ^ (win_r[1] >> 3);
    s1 = {win_r[14][16:0], win_r[14][31:17]} ^ {win_r[14][18:0], win_r[14][31:19]}
       ^ (win_r[14] >> 10);
    w_new = s1 + win_r[9] + s0 + win_r[0];
    e  = v_r[4];
    a  = v_r[0];
    t1 = v_r[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
       + ((e & v_r[5]) ^ (~e & v_r[6])) + sha256_pkg::round_k(rnd_r) + win_r[0];
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_FILL;
      cnt_r        <= 4'd0;
      rnd_r        <= 6'd0;
      fin_r        <= 1'b0;
      oidx_r       <= 3'd0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < 8; i++) hash_r[i] <= sha256_pkg::h_init(3'(i));
    end else begin
      // Drop the held digest word once taken; digest output handles its own
      if (out_tready && state_r != B_OUT) out_tvalid_r <= 1'b0;
      unique case (state_r)
        B_FILL: begin
          if (q_pop) begin
            for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
            win_r[15] <= q_data.word;
            fin_r     <= q_data.fin;
            if (q_data.start) begin
              cnt_r <= 4'd1;
              for (int i = 0; i < 8; i++) hash_r[i] <= sha256_pkg::h_init(3'(i));
            end else begin
              cnt_r <= cnt_r + 4'd1;
              if (cnt_r == 4'd15) begin
                for (int i = 0; i < 8; i++) v_r[i] <= hash_r[i];
                rnd_r   <= 6'd0;
                state_r <= B_COMP;
              end
            end
          end
        end
        B_COMP: begin
          for (int i = 0; i < 15; i++) win_r[i] <= win_r[i+1];
          win_r[15] <= w_new;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= B_ADD;
        end
        B_ADD: begin
          for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + v_r[i];
          oidx_r  <= 3'd0;
          state_r <= fin_r ? B_OUT : B_FILL;
        end
        B_OUT: begin
          // Load the next digest word when the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_data_r   <= hash_r[oidx_r];
            out_idx_r    <= oidx_r;
            out_last_r   <= (oidx_r == 3'd7);
            oidx_r       <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_r[i] <= sha256_pkg::h_init(3'(i));
              state_r <= B_FILL;
            end
          end
        end
        default: state_r <= B_FILL;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_comp_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_COMP && rnd_r == 6'd0) |-> $past(state_r) == B_FILL)
    else $error("compression started outside block fill");
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_last_r) |-> out_idx_r == 3'd7)
    else $error("digest end flag on wrong word");
  a_out_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT) |-> fin_r)
    else $error("digest output without final block");
`endif

endmodule
`default_nettype wire

/* hw/rtl/sha256_hash_core.sv */
// A message's first digest word follows its final padded word through the 64
//   compression rounds, the hash add and the load into the output register.
// Each 64-byte block is filled from the queue and run through the one-round-per-cycle
//   loop; the queue takes input words meanwhile until full. Digest words leave at one
//   per cycle while out_tready is high. Reset (rst_n low, synchronous) clears the
//   queue and loads the initial hash values; schedule and round registers are not cleared.
`default_nettype none
module sha256_hash_core #(
  parameter int unsigned QDEPTH = sha256_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // msg_word[31:0], valid_bytes[34:32], zeros
  input  wire logic        in_tuser,   // first_word
  input  wire logic        in_tlast,   // last_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // digest_word[31:0], word_index[34:32], zeros
  output logic             out_tlast   // digest_last
);

  sha256_pkg::qent_t push_data, pop_data;
  logic push, full, pop, empty;

  sha256_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .q_push(push), .q_data(push_data), .q_full(full)
  );

  sha256_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk, .rst_n, .push, .din(push_data), .full, .pop, .dout(pop_data), .empty
  );

  sha256_back u_back (
    .clk, .rst_n, .q_data(pop_data), .q_empty(empty), .q_pop(pop),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule
`default_nettype wire

/* bench/sha256_hash_core_test.sv */
`default_nettype none
module sha256_hash_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // msg_word[31:0], valid_bytes[34:32], zeros
  logic        in_tuser;   // first_word
  logic        in_tlast;   // last_word
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // digest_word[31:0], word_index[34:32], zeros
  logic        out_tlast;  // digest_last

  sha256_hash_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } digest_t;

  // Software SHA-256 model; holds expected digest words
  class digest_board;
    logic [31:0] hs[8];
    logic [31:0] blk[16];
    logic [63:0] nbits;
    int unsigned nwords;
    digest_t     pending[$];
    int unsigned errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      hs[0] = 32'h6a09e667; hs[1] = 32'hbb67ae85; hs[2] = 32'h3c6ef372;
      hs[3] = 32'ha54ff53a; hs[4] = 32'h510e527f; hs[5] = 32'h9b05688c;
      hs[6] = 32'h1f83d9ab; hs[7] = 32'h5be0cd19;
      nbits = '0;
      nwords = 0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress_block();
      logic [31:0] k[64];
      logic [31:0] v[8];
      logic [31:0] w, t1, t2, x2, x15;
      k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int i = 0; i < 8; i++) v[i] = hs[i];
      for (int t = 0; t < 64; t++) begin
        if (t < 16) begin
          w = blk[t];
        end else begin
          x2 = blk[(t - 2) & 15];
          x15 = blk[(t - 15) & 15];
          w = (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10)) + blk[(t - 7) & 15]
            + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + blk[t & 15];
          blk[t & 15] = w;
        end
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[t] + w;
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        for (int i = 7; i > 0; i--) v[i] = v[i - 1];
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hs[i] += v[i];
    endfunction

    function void put_word(logic [31:0] w);
      blk[nwords] = w;
      nwords++;
      if (nwords == 16) begin
        compress_block();
        nwords = 0;
      end
    endfunction

    // Note an accepted input transfer
    function void note_input(logic [31:0] word, logic [2:0] vb_in, logic first, logic last);
      int unsigned vb;
      logic [31:0] keep;
      digest_t d;
      vb = (vb_in > 4) ? 4 : vb_in;
      if (!last) vb = 4;
      if (first) restart();
      nbits += 64'(8 * vb);
      if (!last) begin
        put_word(word);
        return;
      end
      if (vb < 4) begin
        keep = (vb == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * vb));
        put_word((word & keep) | (32'h80 << (24 - 8 * vb)));
      end else begin
        put_word(word);
        put_word(32'h8000_0000);
      end
      while (nwords != 14) put_word(32'h0);
      put_word(nbits[63:32]);
      put_word(nbits[31:0]);
      for (int j = 0; j < 8; j++) begin
        d.digest_word = hs[j];
        d.word_index = 3'(j);
        d.digest_last = (j == 7);
        pending.push_back(d);
      end
      restart();
    endfunction

    // Check one accepted result transfer against the oldest expectation
    function void check_result(logic [39:0] data, logic last);
      digest_t got, exp_d;
      got.digest_word = data[31:0];
      got.word_index = data[34:32];
      got.digest_last = last;
      if (pending.size() == 0) begin
        $display("%0t: unexpected digest transfer %h", $realtime, got);
        errors++;
        return;
      end
      exp_d = pending.pop_front();
      if (got.digest_word !== exp_d.digest_word) begin
        $display("%0t: digest_word expected %h actual %h", $realtime,
                 exp_d.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== exp_d.word_index) begin
        $display("%0t: word_index expected %0d actual %0d", $realtime,
                 exp_d.word_index, got.word_index);
        errors++;
      end
      if (got.digest_last !== exp_d.digest_last) begin
        $display("%0t: digest_last expected %b actual %b", $realtime,
                 exp_d.digest_last, got.digest_last);
        errors++;
      end
      if (data[39:35] !== 5'b0) begin
        $display("%0t: pad bits expected 0 actual %h", $realtime, data[39:35]);
        errors++;
      end
    endfunction
  endclass

  digest_board board;
  int unsigned cycle;
  bit          calm;      // no idling on either side
  bit          hold_off;  // receiver stalls for a long stretch
  bit          stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles, end on timeout
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) out_tready <= 1'b0;
      else out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
    end
  end

  // Sample results
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tlast);
  end

  // Offer one word and hold it until the transfer
  task automatic send_word(logic [31:0] w, logic [2:0] vb, logic first, logic last);
    while (!calm && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, vb, w};
    in_tuser <= first;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    board.note_input(w, vb, first, last);
  endtask

  // Send a well-formed message of nbytes bytes
  task automatic send_message(int unsigned nbytes, logic first);
    int unsigned nw;
    logic [2:0] vb;
    nw = (nbytes + 3) / 4;
    if (nw == 0) begin
      send_word($urandom, 3'd0, first, 1'b1);
      return;
    end
    for (int unsigned i = 0; i < nw; i++) begin
      vb = (i == nw - 1) ? 3'(nbytes - 4 * i) : 3'($urandom_range(7));
      send_word($urandom, vb, first && i == 0, i == nw - 1);
    end
  endtask

  // Wait until every digest has come out
  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned r;
    board = new();
    cycle = 0;
    calm = 1'b0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, "abc", field extremes, length 448 mod 512
    send_word(32'h0, 3'd0, 1'b1, 1'b1);
    send_word(32'h616263ff, 3'd3, 1'b1, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b0, 1'b1);
    send_word(32'hffffffff, 3'd5, 1'b1, 1'b1);
    send_word(32'h12345678, 3'd1, 1'b0, 1'b1);
    send_word(32'h12345678, 3'd2, 1'b0, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1, 1'b0);  // short word not last counts as four
    send_word(32'h0, 3'd4, 1'b0, 1'b1);
    send_word(32'haaaaaaaa, 3'd4, 1'b1, 1'b0);
    send_word(32'h55555555, 3'd6, 1'b1, 1'b1);  // first drops the partial message
    send_message(56, 1'b1);
    send_message(55, 1'b0);
    in_tvalid <= 1'b0;
    drain();

    // Pressure: receiver stalls while the sender keeps offering
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        send_message(4, 1'b1);
        send_message(8, 1'b1);
        send_message(3, 1'b0);
      end
    join

    // Random: mostly well-formed messages, some noise
    for (int n = 0; n < 60; n++) begin
      calm = (n >= 20 && n < 28);
      r = $urandom_range(99);
      if (r < 80) send_message($urandom_range(r < 10 ? 130 : 20), 1'($urandom_range(1)));
      else send_word($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)),
                     1'($urandom_range(1)));
    end
    send_word($urandom, 3'd4, 1'b0, 1'b1);
    calm = 1'b0;
    in_tvalid <= 1'b0;
    drain();
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
